// ===== hw/rtl/ntc_adc_to_temperature_assert.svh =====
// ---------------------------------------------------------------------------
// ntc_adc_to_temperature assertion macros
// ---------------------------------------------------------------------------
`ifndef NTC_ADC_TO_TEMPERATURE_ASSERT_SVH
`define NTC_ADC_TO_TEMPERATURE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define NTC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define NTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ntc_pkg.sv =====
// ---------------------------------------------------------------------------
// ntc_pkg
// Shared constants, thermistor resistance table and sequencer types.
// ---------------------------------------------------------------------------
`default_nettype none

package ntc_pkg;

    localparam int ADC_FULL_SCALE_DFLT = 4096;
    localparam int ADC_CODE_W          = 12;
    localparam int SER_W               = 20;
    localparam int RES_W               = 32;
    localparam int TEMP_W              = 8;
    localparam int CAN_W               = 8;
    localparam int TABLE_ENTRIES       = 126;
    localparam int IDX_W               = $clog2(TABLE_ENTRIES);
    localparam int OHM_W               = 18;
    localparam int TEMP_OFFSET         = 40;
    localparam int SERIES_RESET        = 10000;

    // thermistor resistance, -40 C first, 1 C steps, descending
    localparam logic [OHM_W-1:0] OHM_ROM [TABLE_ENTRIES] = '{
        18'd193278, 18'd183037, 18'd173310, 18'd164116, 18'd155454, 18'd147302,
        18'd139635, 18'd132422, 18'd125631, 18'd119234, 18'd113203, 18'd107511,
        18'd102136, 18'd97058,  18'd92258,  18'd87717,  18'd83422,  18'd79358,
        18'd75511,  18'd71871,  18'd68424,  18'd65161,  18'd62072,  18'd59146,
        18'd56376,  18'd53752,  18'd51267,  18'd48912,  18'd46680,  18'd44564,
        18'd42558,  18'd40655,  18'd38850,  18'd37136,  18'd35509,  18'd33963,
        18'd32495,  18'd31098,  18'd29771,  18'd28508,  18'd27305,  18'd26161,
        18'd25070,  18'd24032,  18'd23041,  18'd22097,  18'd21196,  18'd20337,
        18'd19517,  18'd18733,  18'd17986,  18'd17271,  18'd16588,  18'd15936,
        18'd15312,  18'd14716,  18'd14146,  18'd13600,  18'd13078,  18'd12579,
        18'd12101,  18'd11644,  18'd11206,  18'd10786,  18'd10385,  18'd10000,
        18'd9632,   18'd9278,   18'd8940,   18'd8616,   18'd8305,   18'd8007,
        18'd7721,   18'd7447,   18'd7184,   18'd6932,   18'd6690,   18'd6458,
        18'd6235,   18'd6021,   18'd5815,   18'd5618,   18'd5428,   18'd5246,
        18'd5071,   18'd4902,   18'd4741,   18'd4585,   18'd4435,   18'd4291,
        18'd4152,   18'd4019,   18'd3891,   18'd3767,   18'd3648,   18'd3533,
        18'd3422,   18'd3316,   18'd3213,   18'd3114,   18'd3019,   18'd2926,
        18'd2838,   18'd2752,   18'd2669,   18'd2589,   18'd2512,   18'd2438,
        18'd2366,   18'd2296,   18'd2229,   18'd2164,   18'd2101,   18'd2041,
        18'd1982,   18'd1926,   18'd1871,   18'd1818,   18'd1767,   18'd1717,
        18'd1669,   18'd1623,   18'd1578,   18'd1534,   18'd1492,   18'd1451
    };

    // table read, zero past the last entry
    function automatic logic [OHM_W-1:0] ohm_at(input logic [IDX_W-1:0] idx);
        logic [OHM_W-1:0] v;
        v = '0;
        if (idx < IDX_W'(TABLE_ENTRIES)) begin
            v = OHM_ROM[idx];
        end
        return v;
    endfunction

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_SRCH,
        S_OUT
    } t_state;

    typedef struct packed {
        logic mul_start;
        logic div_start;
        logic srch_start;
        logic out_load;
    } t_ctl;

endpackage

`default_nettype wire

// ===== hw/rtl/ntc_adc_to_temperature.sv =====
// ---------------------------------------------------------------------------
// ntc_adc_to_temperature
// Thermistor divider ADC code to resistance and nearest table temperature.
// ---------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall with i_adc_code; a word is taken
// when valid is high and stall is low. Output channel: o_out_valid /
// i_out_stall with o_resistance_ohms, o_temperature_c and o_can_code.
// Config channel: i_cfg_valid / o_cfg_ready with i_series_resistor_ohms;
// ready is always high, write only while no word is in flight.
// One word is worked on at a time: the bit-serial multiplier works through
// the 12 code bits, the divider through the 32 quotient bits and the table
// search through the 7 index bits plus the neighbor pick, each with a
// handoff to the next step, and then the output register is loaded.
// A new word is taken only once the sequencer is back in idle.
// The output register holds the result while the receiver stalls, and the
// next word is still taken; a finished result waits inside until the
// output register frees up, and no new word is taken meanwhile.
// Reset (synchronous, active low) returns to idle, drops o_out_valid and
// sets the series resistor to 10000 ohms.
// ---------------------------------------------------------------------------
`default_nettype none

module ntc_adc_to_temperature #(
    parameter int ADC_FULL_SCALE = ntc_pkg::ADC_FULL_SCALE_DFLT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ntc_pkg::ADC_CODE_W-1:0]    i_adc_code,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ntc_pkg::RES_W-1:0]         o_resistance_ohms,
    output logic signed [ntc_pkg::TEMP_W-1:0] o_temperature_c,
    output logic [ntc_pkg::CAN_W-1:0]         o_can_code,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ntc_pkg::SER_W-1:0]         i_series_resistor_ohms
);
    import ntc_pkg::*;

    localparam int DEN_W = $clog2(ADC_FULL_SCALE);
    localparam int FS_W  = $clog2(ADC_FULL_SCALE + 1);
    localparam int CMP_W = (FS_W > ADC_CODE_W) ? FS_W : ADC_CODE_W;

    t_state r_state;
    t_state n_state;
    t_ctl   w_ctl;

    logic [SER_W-1:0]         r_divider_ohms;
    logic [DEN_W-1:0]         r_den;
    logic                     r_out_valid;
    logic [RES_W-1:0]         r_res;
    logic signed [TEMP_W-1:0] r_temp;
    logic [CAN_W-1:0]         r_can;

    logic [CMP_W-1:0]      w_code_ext;
    logic [CMP_W-1:0]      w_code_clamp;
    logic [ADC_CODE_W-1:0] w_code;
    logic [DEN_W-1:0]      n_den;
    logic                  w_out_free;
    logic                  n_out_valid;

    logic [RES_W-1:0] w_prod;
    logic             w_mul_done;
    logic [RES_W-1:0] w_quot;
    logic             w_div_done;
    logic [IDX_W-1:0] w_idx;
    logic             w_srch_done;

    // clamp code into 1 .. full scale - 1
    always_comb begin
        w_code_ext = CMP_W'(i_adc_code);
        if (w_code_ext >= CMP_W'(ADC_FULL_SCALE - 1)) begin
            w_code_clamp = CMP_W'(ADC_FULL_SCALE - 1);
        end else if (w_code_ext == '0) begin
            w_code_clamp = CMP_W'(1);
        end else begin
            w_code_clamp = w_code_ext;
        end
        w_code = ADC_CODE_W'(w_code_clamp);
        n_den  = DEN_W'(CMP_W'(ADC_FULL_SCALE) - w_code_clamp);
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (w_mul_done) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (w_srch_done) begin
                    n_state = w_out_free ? S_IDLE : S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_ctl      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall        = 1'b0;
                w_ctl.mul_start   = i_in_valid;
            end
            S_MUL: begin
                w_ctl.div_start   = w_mul_done;
            end
            S_DIV: begin
                w_ctl.srch_start  = w_div_done;
            end
            S_SRCH: begin
                w_ctl.out_load    = w_srch_done && w_out_free;
            end
            S_OUT: begin
                w_ctl.out_load    = w_out_free;
            end
            default: begin
                o_in_stall        = 1'b1;
            end
        endcase
    end

    assign n_out_valid = w_ctl.out_load || (r_out_valid && i_out_stall);

    ntc_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_ctl.mul_start),
        .i_series (r_divider_ohms),
        .i_code   (w_code),
        .o_prod   (w_prod),
        .o_done   (w_mul_done)
    );

    ntc_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ctl.div_start),
        .i_num   (w_prod),
        .i_den   (r_den),
        .o_quot  (w_quot),
        .o_done  (w_div_done)
    );

    ntc_srch u_srch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ctl.srch_start),
        .i_ohms  (w_quot),
        .o_idx   (w_idx),
        .o_done  (w_srch_done)
    );

    always_ff @(posedge i_clk) begin
        if (w_ctl.mul_start) begin
            r_den <= n_den;
        end
        if (w_ctl.out_load) begin
            r_res  <= w_quot;
            r_temp <= TEMP_W'({1'b0, w_idx}) - TEMP_W'(TEMP_OFFSET);
            r_can  <= CAN_W'({w_idx, 1'b0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_divider_ohms <= SER_W'(SERIES_RESET);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_divider_ohms <= i_series_resistor_ohms;
            end
        end
    end

    assign o_cfg_ready       = 1'b1;
    assign o_out_valid       = r_out_valid;
    assign o_resistance_ohms = r_res;
    assign o_temperature_c   = r_temp;
    assign o_can_code        = r_can;

`include "ntc_adc_to_temperature_assert.svh"

    `NTC_ASSERT_NEXT(a_accept_starts_mul, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state == S_MUL, "accepted word did not start the multiplier")
    `NTC_ASSERT_NEXT(a_search_gives_result, i_clk, i_rst_n, r_state == S_SRCH && w_srch_done, o_out_valid, "finished search left no valid result")
    `NTC_ASSERT_NOW(a_can_matches_temp, i_clk, i_rst_n, o_out_valid, o_can_code == CAN_W'((o_temperature_c + 8'sd40) << 1), "can code does not match temperature")

endmodule

`default_nettype wire

// ===== hw/rtl/ntc_mul.sv =====
// ---------------------------------------------------------------------------
// ntc_mul
// Bit-serial shift-add multiplier: series resistor times clamped code,
// one code bit per cycle, msb first.
// ---------------------------------------------------------------------------
`default_nettype none

module ntc_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ntc_pkg::SER_W-1:0]  i_series,
    input  logic [ntc_pkg::ADC_CODE_W-1:0] i_code,
    output logic [ntc_pkg::RES_W-1:0]  o_prod,
    output logic                       o_done
);
    import ntc_pkg::*;

    localparam int CNT_W = $clog2(ADC_CODE_W);

    logic [SER_W-1:0]      r_a;
    logic [ADC_CODE_W-1:0] r_b;
    logic [RES_W-1:0]      r_acc;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [RES_W-1:0]      n_acc;
    logic [CNT_W-1:0]      n_cnt;
    logic                  n_busy;
    logic                  n_done;

    always_comb begin
        n_acc = {r_acc[RES_W-2:0], 1'b0} + (r_b[ADC_CODE_W-1] ? RES_W'(r_a) : '0);
    end

    always_comb begin
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_cnt  = CNT_W'(ADC_CODE_W - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_series;
            r_b   <= i_code;
            r_acc <= '0;
        end else if (r_busy) begin
            r_b   <= {r_b[ADC_CODE_W-2:0], 1'b0};
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_prod = r_acc;
    assign o_done = r_done;

endmodule

`default_nettype wire

// ===== hw/rtl/ntc_div.sv =====
// ---------------------------------------------------------------------------
// ntc_div
// Restoring radix-2 divider: one quotient bit per cycle, the quotient
// shifts into the numerator register.
// ---------------------------------------------------------------------------
`default_nettype none

module ntc_div #(
    parameter int DEN_W = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ntc_pkg::RES_W-1:0] i_num,
    input  logic [DEN_W-1:0]          i_den,
    output logic [ntc_pkg::RES_W-1:0] o_quot,
    output logic                      o_done
);
    import ntc_pkg::*;

    localparam int CNT_W = $clog2(RES_W);

    logic [RES_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   w_rem_sh;
    logic             w_ge;
    logic [DEN_W-1:0] n_rem;
    logic [CNT_W-1:0] n_cnt;
    logic             n_busy;
    logic             n_done;

    // partial remainder stays below the divisor, so DEN_W bits hold it
    always_comb begin
        w_rem_sh = {r_rem, r_num[RES_W-1]};
        w_ge     = (w_rem_sh >= {1'b0, r_den});
        n_rem    = w_ge ? DEN_W'(w_rem_sh - {1'b0, r_den}) : w_rem_sh[DEN_W-1:0];
    end

    always_comb begin
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_cnt  = CNT_W'(RES_W - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[RES_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_quot = r_num;
    assign o_done = r_done;

endmodule

`default_nettype wire

// ===== hw/rtl/ntc_srch.sv =====
// ---------------------------------------------------------------------------
// ntc_srch
// Nearest-entry search of the resistance table: one index bit per cycle,
// then a final step that picks between the bracketing neighbors.
// ---------------------------------------------------------------------------
`default_nettype none

module ntc_srch (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ntc_pkg::RES_W-1:0] i_ohms,
    output logic [ntc_pkg::IDX_W-1:0] o_idx,
    output logic                      o_done
);
    import ntc_pkg::*;

    localparam int BIT_W = $clog2(IDX_W);

    logic [RES_W-1:0] r_ohms;
    logic [IDX_W-1:0] r_idx;
    logic [BIT_W-1:0] r_bit;
    logic             r_busy;
    logic             r_last;
    logic             r_done;

    logic [IDX_W-1:0] w_try;
    logic             w_take;
    logic [OHM_W-1:0] w_hi;
    logic [OHM_W-1:0] w_lo;
    logic [OHM_W-1:0] w_d_hi;
    logic [OHM_W-1:0] w_d_lo;
    logic [IDX_W-1:0] w_pick;
    logic [IDX_W-1:0] n_idx;
    logic [BIT_W-1:0] n_bit;
    logic             n_busy;
    logic             n_last;
    logic             n_done;

    // largest index whose entry is still at or above the resistance
    always_comb begin
        w_try  = r_idx | (IDX_W'(1) << r_bit);
        w_take = (w_try < IDX_W'(TABLE_ENTRIES))
                 && (RES_W'(ohm_at(w_try)) >= r_ohms);
    end

    // bracket case: entry idx >= ohms > entry idx+1, both below 2^OHM_W
    always_comb begin
        w_hi   = ohm_at(r_idx);
        w_lo   = ohm_at(r_idx + 1'b1);
        w_d_hi = w_hi - r_ohms[OHM_W-1:0];
        w_d_lo = r_ohms[OHM_W-1:0] - w_lo;
        if (r_ohms >= RES_W'(OHM_ROM[0])) begin
            w_pick = '0;
        end else if (r_ohms <= RES_W'(OHM_ROM[TABLE_ENTRIES-1])) begin
            w_pick = IDX_W'(TABLE_ENTRIES - 1);
        end else if (w_d_hi < w_d_lo) begin
            w_pick = r_idx;
        end else begin
            // tie goes to the hotter entry
            w_pick = r_idx + 1'b1;
        end
    end

    always_comb begin
        n_idx  = r_idx;
        n_bit  = r_bit;
        n_busy = r_busy;
        n_last = r_last;
        n_done = 1'b0;
        if (i_start) begin
            n_idx  = '0;
            n_bit  = BIT_W'(IDX_W - 1);
            n_busy = 1'b1;
            n_last = 1'b0;
        end else if (r_busy && r_last) begin
            n_idx  = w_pick;
            n_busy = 1'b0;
            n_last = 1'b0;
            n_done = 1'b1;
        end else if (r_busy) begin
            if (w_take) begin
                n_idx = w_try;
            end
            if (r_bit == '0) begin
                n_last = 1'b1;
            end else begin
                n_bit = r_bit - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ohms <= i_ohms;
        end
        r_idx <= n_idx;
        r_bit <= n_bit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_last <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_last <= n_last;
            r_done <= n_done;
        end
    end

    assign o_idx  = r_idx;
    assign o_done = r_done;

endmodule

`default_nettype wire

// ===== sim/temperature_checker.sv =====
// ---------------------------------------------------------------------------
// temperature_checker
// Watches the ADC, result and resistor channels of ntc_adc_to_temperature,
// predicts resistance, temperature and bus code for every word taken and
// compares each delivered result against the oldest prediction.
// ---------------------------------------------------------------------------
module temperature_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic [ntc_pkg::ADC_CODE_W-1:0]    i_adc_code,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic [ntc_pkg::RES_W-1:0]         i_resistance_ohms,
    input  logic signed [ntc_pkg::TEMP_W-1:0] i_temperature_c,
    input  logic [ntc_pkg::CAN_W-1:0]         i_can_code,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [ntc_pkg::SER_W-1:0]         i_series_ohms,
    output int                                o_mismatches,
    output int                                o_pending,
    output int                                o_compared
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned ADC_SPAN = ntc_pkg::ADC_FULL_SCALE_DFLT;
    localparam int LAST_ENTRY = ntc_pkg::TABLE_ENTRIES - 1;

    // thermistor ohms from -40 C to 85 C in 1 C steps
    localparam int unsigned THERM_OHMS [ntc_pkg::TABLE_ENTRIES] = '{
        193278, 183037, 173310, 164116, 155454, 147302, 139635, 132422, 125631, 119234,
        113203, 107511, 102136, 97058,  92258,  87717,  83422,  79358,  75511,  71871,
        68424,  65161,  62072,  59146,  56376,  53752,  51267,  48912,  46680,  44564,
        42558,  40655,  38850,  37136,  35509,  33963,  32495,  31098,  29771,  28508,
        27305,  26161,  25070,  24032,  23041,  22097,  21196,  20337,  19517,  18733,
        17986,  17271,  16588,  15936,  15312,  14716,  14146,  13600,  13078,  12579,
        12101,  11644,  11206,  10786,  10385,  10000,  9632,   9278,   8940,   8616,
        8305,   8007,   7721,   7447,   7184,   6932,   6690,   6458,   6235,   6021,
        5815,   5618,   5428,   5246,   5071,   4902,   4741,   4585,   4435,   4291,
        4152,   4019,   3891,   3767,   3648,   3533,   3422,   3316,   3213,   3114,
        3019,   2926,   2838,   2752,   2669,   2589,   2512,   2438,   2366,   2296,
        2229,   2164,   2101,   2041,   1982,   1926,   1871,   1818,   1767,   1717,
        1669,   1623,   1578,   1534,   1492,   1451
    };

    typedef struct {
        logic [ntc_pkg::RES_W-1:0]         ohms;
        logic signed [ntc_pkg::TEMP_W-1:0] temp_c;
        logic [ntc_pkg::CAN_W-1:0]         can;
    } t_reading;

    t_reading                  expected_readings [$];
    logic [ntc_pkg::SER_W-1:0] series_ohms;
    int                        mismatch_count;
    int                        compared_count;

    assign o_mismatches = mismatch_count;
    assign o_compared   = compared_count;

    // nearest table entry, ties go to the hotter one
    function automatic int nearest_entry(input int unsigned ohms);
        if (ohms >= THERM_OHMS[0]) begin
            return 0;
        end
        if (ohms <= THERM_OHMS[LAST_ENTRY]) begin
            return LAST_ENTRY;
        end
        for (int k = 0; k < LAST_ENTRY; k++) begin
            if (ohms <= THERM_OHMS[k] && ohms > THERM_OHMS[k+1]) begin
                return ((THERM_OHMS[k] - ohms) < (ohms - THERM_OHMS[k+1])) ? k : k + 1;
            end
        end
        return LAST_ENTRY;
    endfunction

    function automatic t_reading code_to_reading(input logic [ntc_pkg::ADC_CODE_W-1:0] code,
                                                 input logic [ntc_pkg::SER_W-1:0] ser);
        longint unsigned clamped;
        longint unsigned quotient;
        int              idx;
        t_reading        rd;
        clamped = code;
        if (clamped >= ADC_SPAN - 1) begin
            clamped = ADC_SPAN - 1;
        end
        if (clamped == 0) begin
            clamped = 1;
        end
        quotient = (longint'(ser) * clamped) / (ADC_SPAN - clamped);
        if (quotient > 64'hFFFF_FFFF) begin
            quotient = 64'hFFFF_FFFF;
        end
        idx       = nearest_entry(quotient[31:0]);
        rd.ohms   = quotient[31:0];
        rd.temp_c = 8'(idx - ntc_pkg::TEMP_OFFSET);
        rd.can    = 8'(idx * 2);
        return rd;
    endfunction

    task automatic report(input string what);
        $display("[%0t] %s", $time, what);
        mismatch_count++;
    endtask

    initial begin
        mismatch_count = 0;
        compared_count = 0;
        o_pending      = 0;
        series_ohms    = ntc_pkg::SERIES_RESET;
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            series_ohms = ntc_pkg::SERIES_RESET;
            expected_readings.delete();
        end else begin
            // check the outgoing word before queuing the incoming one
            if (i_out_valid && !i_out_stall) begin
                if (expected_readings.size() == 0) begin
                    report($sformatf("unexpected result: %0d ohms, %0d C, can %0d",
                                     i_resistance_ohms, i_temperature_c, i_can_code));
                end else begin
                    want = expected_readings.pop_front();
                    compared_count++;
                    if (i_resistance_ohms !== want.ohms) begin
                        report($sformatf("resistance %0d ohms, want %0d",
                                         i_resistance_ohms, want.ohms));
                    end
                    if (i_temperature_c !== want.temp_c) begin
                        report($sformatf("temperature %0d C, want %0d (at %0d ohms)",
                                         i_temperature_c, want.temp_c, want.ohms));
                    end
                    if (i_can_code !== want.can) begin
                        report($sformatf("can code %0d, want %0d", i_can_code, want.can));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_readings.push_back(code_to_reading(i_adc_code, series_ohms));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                series_ohms = i_series_ohms;
            end
        end
        o_pending = expected_readings.size();
    end

endmodule

// ===== sim/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Drives ADC codes and series resistor settings into ntc_adc_to_temperature
// with random idling on both channels, then back-to-back; temperature_checker
// predicts and compares every result, and this module gives the verdict.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES          = 12;
    localparam int WORDS_PER_PHASE = 100;
    localparam int SETTLE_CYCLES   = 64;
    localparam logic [ntc_pkg::ADC_CODE_W-1:0] MID_CODE = 12'd2048;
    localparam logic [ntc_pkg::SER_W-1:0]      SER_MAX  = 20'hFFFFF;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_stall;
    logic [ntc_pkg::ADC_CODE_W-1:0]    i_adc_code = '0;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    logic [ntc_pkg::RES_W-1:0]         o_resistance_ohms;
    logic signed [ntc_pkg::TEMP_W-1:0] o_temperature_c;
    logic [ntc_pkg::CAN_W-1:0]         o_can_code;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [ntc_pkg::SER_W-1:0]         i_series_resistor_ohms = '0;

    int mismatches;
    int pending;
    int compared;
    int tx_gap_pct = 38;
    int rx_stall_pct = 48;
    int words_sent = 0;
    int settings_used = 0;

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    ntc_adc_to_temperature u_top (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_adc_code             (i_adc_code),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_resistance_ohms      (o_resistance_ohms),
        .o_temperature_c        (o_temperature_c),
        .o_can_code             (o_can_code),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_series_resistor_ohms (i_series_resistor_ohms)
    );

    temperature_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_adc_code        (i_adc_code),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_resistance_ohms (o_resistance_ohms),
        .i_temperature_c   (o_temperature_c),
        .i_can_code        (o_can_code),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_series_ohms     (i_series_resistor_ohms),
        .o_mismatches      (mismatches),
        .o_pending         (pending),
        .o_compared        (compared)
    );

    // mostly uniform, with weight on the clamped ends and on mid scale,
    // where the resistance equals the series resistor
    function automatic logic [ntc_pkg::ADC_CODE_W-1:0] pick_code();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 12'($urandom_range(0, 4095));
        end
        if (roll < 75) begin
            case ($urandom_range(0, 3))
                0: return 12'd0;
                1: return 12'd1;
                2: return 12'd4094;
                default: return 12'd4095;
            endcase
        end
        if (roll < 90) begin
            return MID_CODE;
        end
        return 12'(MID_CODE - 64 + $urandom_range(0, 128));
    endfunction

    // valid stays high from one word to the next unless a gap is drawn
    task automatic offer_code(input logic [ntc_pkg::ADC_CODE_W-1:0] code);
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_adc_code <= code;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
    endtask

    // hold off until every outstanding result has been delivered
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic set_series(input logic [ntc_pkg::SER_W-1:0] ohms);
        wait_idle();
        i_cfg_valid            <= 1'b1;
        i_series_resistor_ohms <= ohms;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial begin
        logic [ntc_pkg::ADC_CODE_W-1:0] corner_codes [10];
        logic [ntc_pkg::SER_W-1:0]      ser;
        int                             nb;
        corner_codes = '{12'd0, 12'd1, 12'd2, 12'd2048, 12'd4094, 12'd4095,
                         12'hAAA, 12'h555, 12'h800, 12'h7FF};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset resistor value: clamped ends, exact 25 C, bit patterns
        foreach (corner_codes[k]) begin
            offer_code(corner_codes[k]);
        end
        // mid scale gives exactly the resistor, halfway between 25 C and 26 C
        set_series(20'd9816);
        offer_code(MID_CODE);
        offer_code(MID_CODE - 1);
        offer_code(MID_CODE + 1);
        // first and last table entries hit exactly, and just above the last
        set_series(20'd193278);
        offer_code(MID_CODE);
        set_series(20'd1451);
        offer_code(MID_CODE);
        set_series(20'd1452);
        offer_code(MID_CODE);
        // zero, full-width and one-ohm resistor
        set_series(20'd0);
        offer_code(12'd0);
        offer_code(12'd4095);
        set_series(SER_MAX);
        offer_code(12'd4095);
        offer_code(12'd1);
        set_series(20'd1);
        offer_code(12'd4095);
        offer_code(MID_CODE);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph / 4)
                0: begin
                    tx_gap_pct   = 38;
                    rx_stall_pct = 48;
                end
                1: begin
                    tx_gap_pct   = 48;
                    rx_stall_pct = 38;
                end
                default: begin
                    tx_gap_pct   = 0;
                    rx_stall_pct = 0;
                end
            endcase
            case (ph % 6)
                0: ser = 20'(ntc_pkg::SERIES_RESET);
                1: ser = 20'd1;
                2: ser = SER_MAX;
                3: ser = 20'd1000000;
                4: begin
                    // midpoint of two neighbors, rounded down, so mid-scale codes land on or next to ties
                    nb  = $urandom_range(0, ntc_pkg::TABLE_ENTRIES - 2);
                    ser = (20'(ntc_pkg::OHM_ROM[nb]) + 20'(ntc_pkg::OHM_ROM[nb+1])) / 2;
                end
                default: ser = 20'($urandom_range(0, SER_MAX));
            endcase
            set_series(ser);
            repeat (WORDS_PER_PHASE) offer_code(pick_code());
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d ADC words sent across %0d series resistor settings, 0 to %0d ohms",
                 words_sent, settings_used, SER_MAX);
        $display("%0d results compared; idling on both sides, then back-to-back", compared);
        if (pending != 0) begin
            $display("%0d expected results never arrived", pending);
        end
        if (mismatches == 0 && pending == 0) begin
            $display("ntc_adc_to_temperature: match");
        end else begin
            $display("ntc_adc_to_temperature: mismatch");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timed out waiting on the block");
        $display("ntc_adc_to_temperature: mismatch");
        $finish;
    end

endmodule
